// ----- sv/krmt_pkg.sv -----
package krmt_pkg;

   localparam int ID_W       = 16;
   localparam int LEN_W      = 10;
   localparam int CHAR_W     = 8;
   localparam int KEY_CHARS  = 5;
   localparam int LETTER_W   = 5;
   localparam int KEY_W      = KEY_CHARS * LETTER_W;
   localparam int WAIT_W     = 5;
   localparam int OUTCOME_W  = 2;

   localparam logic [LEN_W-1:0]  KEY_LEN = LEN_W'(KEY_CHARS);
   localparam logic [CHAR_W-1:0] CHAR_LO = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_HI = 8'h7a;

   localparam logic [OUTCOME_W-1:0] OUT_INVALID = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_WAITING = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_PAIRED  = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_FULL    = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ID_W-1:0]   connection_id;
      logic [LEN_W-1:0]  key_length;
      logic [CHAR_W-1:0] key_char0;
      logic [CHAR_W-1:0] key_char1;
      logic [CHAR_W-1:0] key_char2;
      logic [CHAR_W-1:0] key_char3;
      logic [CHAR_W-1:0] key_char4;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [ID_W-1:0]      partner_id;
      logic [WAIT_W-1:0]    waiting_count;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic             key_ok;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
   } job_type;

   // front/back queue handshake
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
   } entry_type;

endpackage

// ----- sv/krmt_ram.sv -----
module krmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/krmt_front.sv -----
module krmt_front
   import krmt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           pop
);

   logic [CHAR_W-1:0]  chars [KEY_CHARS];
   logic               key_ok;
   logic [KEY_W-1:0]   key;
   logic               push;

   job_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;

   assign chars[0] = req_data.key_char0;
   assign chars[1] = req_data.key_char1;
   assign chars[2] = req_data.key_char2;
   assign chars[3] = req_data.key_char3;
   assign chars[4] = req_data.key_char4;

   always_comb begin
      key_ok = (req_data.key_length == KEY_LEN);
      key    = '0;
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (chars[i] < CHAR_LO || chars[i] > CHAR_HI) begin
            key_ok = 1'b0;
         end
         key[i*LETTER_W +: LETTER_W] = LETTER_W'(chars[i] - CHAR_LO);
      end
   end

   assign busy = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign push = start && !busy;

   assign head.valid = (fill_ff != '0);
   assign head.job   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         fill_in = QFILL_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = QFILL_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{key_ok: key_ok, key: key, id: req_data.connection_id};
      end
   end

endmodule

// ----- sv/krmt_back.sv -----
module krmt_back
   import krmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [CW-1:0]   addr_ff, addr_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pidx_ff, pidx_in;
   logic [CW-1:0]   count_ff, count_in;
   job_type         job_ff, job_in;
   logic [ID_W-1:0] partner_ff, partner_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            we;
   logic [AW-1:0]   waddr;
   entry_type       wentry;
   entry_type       rentry;
   logic            issue;

   krmt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wentry),
      .raddr (addr_ff[AW-1:0]),
      .rdata (rentry)
   );

   assign issue = (addr_ff < count_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      count_in     = count_ff;
      job_in       = job_ff;
      partner_in   = partner_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      we           = 1'b0;
      waddr        = pidx_ff;
      wentry       = rentry;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               job_in = head.job;
               if (!head.job.key_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{outcome: OUT_INVALID, partner_id: '0,
                                   waiting_count: WAIT_W'(count_ff)};
               end else begin
                  addr_in  = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read data arrives in the cycle after its address is issued
            if (pend_ff && rentry.key == job_ff.key) begin
               partner_in = rentry.id;
               addr_in    = CW'(CW'(pidx_ff) + 1'b1);
               pend_in    = 1'b0;
               state_in   = ST_SHIFT;
            end else if (issue) begin
               addr_in = CW'(addr_ff + 1'b1);
               pend_in = 1'b1;
               pidx_in = addr_ff[AW-1:0];
            end else begin
               pend_in  = 1'b0;
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (count_ff == FULL_COUNT) begin
                  rsp_in = '{outcome: OUT_FULL, partner_id: '0,
                             waiting_count: WAIT_W'(count_ff)};
               end else begin
                  we       = 1'b1;
                  waddr    = count_ff[AW-1:0];
                  wentry   = '{key: job_ff.key, id: job_ff.id};
                  count_in = CW'(count_ff + 1'b1);
                  rsp_in   = '{outcome: OUT_WAITING, partner_id: '0,
                               waiting_count: WAIT_W'(count_ff + 1'b1)};
               end
            end
         end
         ST_SHIFT: begin
            // close the gap: entry j+1 is read, then written to j in the cycle after
            if (pend_ff) begin
               we = 1'b1;
            end
            if (issue) begin
               addr_in = CW'(addr_ff + 1'b1);
               pend_in = 1'b1;
               pidx_in = AW'(addr_ff - 1'b1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in     = CW'(count_ff - 1'b1);
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{outcome: OUT_PAIRED, partner_id: partner_ff,
                                waiting_count: WAIT_W'(count_ff - 1'b1)};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      pidx_ff    <= pidx_in;
      job_ff     <= job_in;
      partner_ff <= partner_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/key_rendezvous_match_table_top.sv -----
// Channel   Handshake              Payload             Notes
// request   start && !busy         req_data (req_type) busy = 2-deep queue full
// response  rsp_valid (1 cycle)    rsp_data (rsp_type) one per request, in order
//
// Invalid key: answered by the idle back part when it pops the request; the response is registered.
// Valid key: one table read per cycle over the n waiting entries, through the single read port;
// a match shifts later entries down one per cycle. Queued requests wait for those ahead.
// Synchronous reset empties the queue and the table count; table contents are kept.
// The response side cannot stall; busy only reflects the front queue filling up.
module key_rendezvous_match_table_top
   import krmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   queue_head_type head;
   logic           pop;

   krmt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .head     (head),
      .pop      (pop)
   );

   krmt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/krmt_checker.sv -----
module krmt_checker
   import krmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // nothing in flight right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or response right after reset");

   a_partner_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome != OUT_PAIRED |-> rsp_data.partner_id == '0)
      else $error("partner id set on unpaired response");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == OUT_FULL
         |-> rsp_data.waiting_count == WAIT_W'(TABLE_DEPTH))
      else $error("full response with table not full");

   // the queue only fills through an accepted transaction
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

endmodule

bind key_rendezvous_match_table_top krmt_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_krmt_checker (.*);
